[rtl/tmgr_pkg.sv]
// Shared types and constants of the text-mode glyph renderer.
// No dependencies; every other rtl file imports this package.
package tmgr_pkg;

  // Font store geometry and glyph limits
  localparam int FONT_BYTES       = 16384;
  localparam int FONT_AW          = $clog2(FONT_BYTES);
  localparam int MAX_GLYPH_WIDTH  = 16;
  localparam int MAX_GLYPH_HEIGHT = 32;
  localparam int BYTE_BITS        = 8;

  // Register and counter widths
  localparam int FW_W  = 5;
  localparam int FH_W  = 6;
  localparam int CNT_W = $clog2(MAX_GLYPH_WIDTH);
  localparam int PAL_N = 16;
  localparam int PAL_AW = $clog2(PAL_N);

  // Command codes
  localparam logic [1:0] CMD_FONT_WR = 2'd0;
  localparam logic [1:0] CMD_PAL_WR  = 2'd1;
  localparam logic [1:0] CMD_RENDER  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FONT_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FONT_HEIGHT = 2'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [13:0] addr;
    logic [23:0] wdata;
    logic [15:0] cell_word;
    logic [5:0]  cell_row;
    logic [7:0]  cell_col;
    logic [4:0]  scan_line;
  } tmgr_in_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [10:0] pixel_y;
    logic [23:0] pixel_color;
    logic        last_pixel;
  } tmgr_out_t;

  // One decoded item on its way from the front stages to the scan sequencer
  typedef struct packed {
    logic [1:0]         cmd;
    logic [FONT_AW-1:0] addr;
    logic [23:0]        wdata;
    logic [3:0]         fg;
    logic [3:0]         bg;
    logic [FONT_AW-1:0] lbase;
    logic [11:0]        colfw;
    logic [10:0]        pix_y;
  } tmgr_line_t;

  // One fetched pixel, before palette resolution
  typedef struct packed {
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic [2:0]  bit_sel;
    logic [7:0]  font_byte;
    logic [23:0] fg_raw;
    logic [23:0] bg_raw;
    logic        fg_ok;
    logic        bg_ok;
    logic [11:0] pixel_x;
    logic [10:0] pixel_y;
    logic        last;
  } tmgr_pix_t;

  // Default sixteen-color palette
  function automatic logic [23:0] ega_color(input logic [3:0] idx);
    logic [23:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'hAA0000;
      4'd2:    c = 24'h00AA00;
      4'd3:    c = 24'hAAAA00;
      4'd4:    c = 24'h0000AA;
      4'd5:    c = 24'hAA00AA;
      4'd6:    c = 24'h00AAAA;
      4'd7:    c = 24'hAAAAAA;
      4'd8:    c = 24'h555555;
      4'd9:    c = 24'hFF5555;
      4'd10:   c = 24'h55FF55;
      4'd11:   c = 24'hFFFF55;
      4'd12:   c = 24'h5555FF;
      4'd13:   c = 24'hFF55FF;
      4'd14:   c = 24'h55FFFF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

endpackage

[rtl/text_mode_glyph_renderer_unit.sv]
// Top level of the text-mode glyph renderer: configuration registers, output
// stage with palette resolution. Depends on tmgr_pkg, tmgr_front, tmgr_scan.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------
//   in      | in_valid / in_ready   | in_data  (tmgr_in_t: command item)
//   out     | out_valid / out_ready | out_data (tmgr_out_t: one pixel)
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_wdata (always ready)
//
// A render item occupies the scan sequencer for one step per glyph column (1..16, 8
// after reset), one pixel per cycle unless the output stalls; a font or palette write
// takes one step there, a dropped item none. The sequencer is the only multi-cycle unit:
// items enter back to back and queue in the three front stages. A render item's first
// pixel then passes the sequencer, fetch and output registers. Reset is synchronous and
// clears all valid bits and the palette-written flags; the font store keeps whatever it
// holds. A stall on the output freezes the sequencer and fetch stage in place.
module text_mode_glyph_renderer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmgr_pkg::tmgr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tmgr_pkg::tmgr_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [5:0]          cfg_wdata
);
  import tmgr_pkg::*;

  logic [FW_W-1:0] fw_r, fw_nxt;
  logic [FH_W-1:0] fh_r, fh_nxt;
  logic            adv;
  logic            line_valid, line_take;
  tmgr_line_t      line;
  logic            pix_valid;
  tmgr_pix_t       pix;
  logic            bit_set;
  logic [23:0]     fg_color, bg_color;
  logic            out_valid_r;
  tmgr_out_t       out_r, out_nxt;

  // Configuration writes are always taken; store the clamped dimension
  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_wdata[FW_W-1:0] == '0) begin
      fw_nxt = FW_W'(1);
    end else if (cfg_wdata[FW_W-1:0] > FW_W'(MAX_GLYPH_WIDTH)) begin
      fw_nxt = FW_W'(MAX_GLYPH_WIDTH);
    end else begin
      fw_nxt = cfg_wdata[FW_W-1:0];
    end
    if (cfg_wdata == '0) begin
      fh_nxt = FH_W'(1);
    end else if (cfg_wdata > FH_W'(MAX_GLYPH_HEIGHT)) begin
      fh_nxt = FH_W'(MAX_GLYPH_HEIGHT);
    end else begin
      fh_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_W'(8);
      fh_r <= FH_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FONT_WIDTH:  fw_r <= fw_nxt;
        CFG_FONT_HEIGHT: fh_r <= fh_nxt;
        default: ;
      endcase
    end
  end

  // Everything past the front stages advances when the output register frees up
  assign adv = !out_valid_r || out_ready;

  tmgr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .fw         (fw_r),
    .fh         (fh_r),
    .line_valid (line_valid),
    .line       (line),
    .line_take  (line_take)
  );

  tmgr_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .fw         (fw_r),
    .line_valid (line_valid),
    .line       (line),
    .line_take  (line_take),
    .pix_valid  (pix_valid),
    .pix        (pix)
  );

  // Font bits are MSB first: bit position b selects byte bit 7-b
  assign bit_set  = pix.font_byte[~pix.bit_sel];
  assign fg_color = pix.fg_ok ? pix.fg_raw : ega_color(pix.fg);
  assign bg_color = pix.bg_ok ? pix.bg_raw : ega_color(pix.bg);

  always_comb begin
    out_nxt.pixel_x     = pix.pixel_x;
    out_nxt.pixel_y     = pix.pixel_y;
    out_nxt.pixel_color = bit_set ? fg_color : bg_color;
    out_nxt.last_pixel  = pix.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // A held pixel must not be replaced while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("pixel changed under stall");
`endif

endmodule

[rtl/tmgr_front.sv]
// Front stages: decode and drop, three small multiplies, line base address.
// Depends on tmgr_pkg.
module tmgr_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tmgr_pkg::tmgr_in_t     in_data,
  input  logic [tmgr_pkg::FW_W-1:0] fw,
  input  logic [tmgr_pkg::FH_W-1:0] fh,
  output logic                   line_valid,
  output tmgr_pkg::tmgr_line_t   line,
  input  logic                   line_take
);
  import tmgr_pkg::*;

  logic        s1_v_r, s2_v_r, s3_v_r;
  logic        s1_rdy, s2_rdy, s3_rdy;
  logic        keep;
  tmgr_in_t    s1_r;
  logic [1:0]  s2_cmd_r;
  logic [FONT_AW-1:0] s2_addr_r;
  logic [23:0] s2_wdata_r;
  logic [3:0]  s2_fg_r, s2_bg_r;
  logic [4:0]  s2_scan_r;
  logic [13:0] s2_chfh_r;
  logic [10:0] s2_rowfh_r;
  logic [11:0] s2_colfw_r;
  logic [13:0] lsum;
  tmgr_line_t  s3_nxt, s3_r;

  assign s3_rdy   = !s3_v_r || line_take;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // Drop items that give nothing: bad palette index, scanline at or past height, unused code
  always_comb begin
    case (in_data.cmd)
      CMD_FONT_WR: keep = 1'b1;
      CMD_PAL_WR:  keep = (in_data.addr[13:PAL_AW] == '0);
      CMD_RENDER:  keep = ({1'b0, in_data.scan_line} < fh);
      default:     keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid && keep;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) s1_r <= in_data;
    if (s2_rdy) begin
      s2_cmd_r   <= s1_r.cmd;
      s2_addr_r  <= s1_r.addr;
      s2_wdata_r <= s1_r.wdata;
      s2_fg_r    <= s1_r.cell_word[11:8];
      s2_bg_r    <= s1_r.cell_word[15:12];
      s2_scan_r  <= s1_r.scan_line;
      s2_chfh_r  <= 14'(s1_r.cell_word[7:0]) * 14'(fh);
      s2_rowfh_r <= 11'(s1_r.cell_row) * 11'(fh);
      s2_colfw_r <= 12'(s1_r.cell_col) * 12'(fw);
    end
    if (s3_rdy) s3_r <= s3_nxt;
  end

  // Byte offset of the glyph line: (char*height + scan) * bytes per line
  assign lsum = s2_chfh_r + 14'(s2_scan_r);

  always_comb begin
    s3_nxt.cmd   = s2_cmd_r;
    s3_nxt.addr  = s2_addr_r;
    s3_nxt.wdata = s2_wdata_r;
    s3_nxt.fg    = s2_fg_r;
    s3_nxt.bg    = s2_bg_r;
    s3_nxt.lbase = (fw > FW_W'(BYTE_BITS)) ? FONT_AW'({lsum, 1'b0}) : FONT_AW'(lsum);
    s3_nxt.colfw = s2_colfw_r;
    s3_nxt.pix_y = s2_rowfh_r + 11'(s2_scan_r);
  end

  assign line_valid = s3_v_r;
  assign line       = s3_r;

`ifndef NO_ASSERTIONS
  // Input may only be held off while every front stage holds an item
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && s2_v_r && s3_v_r))
    else $error("front stalled with an empty stage");
`endif

endmodule

[rtl/tmgr_scan.sv]
// Scan sequencer: steps through the pixels of a line, owns the font and palette memories,
// and registers one fetched pixel per cycle unless the output stalls. Depends on tmgr_pkg.
module tmgr_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [tmgr_pkg::FW_W-1:0] fw,
  input  logic                      line_valid,
  input  tmgr_pkg::tmgr_line_t      line,
  output logic                      line_take,
  output logic                      pix_valid,
  output tmgr_pkg::tmgr_pix_t       pix
);
  import tmgr_pkg::*;

  logic [7:0]  font_mem [FONT_BYTES];
  logic [23:0] pal_mem [PAL_N];
  logic [PAL_N-1:0] pal_ok_r;

  logic        ex_v_r;
  tmgr_line_t  ex_r;
  logic [CNT_W-1:0] cnt_r;
  logic [FW_W-1:0]  fw_m1_full;
  logic [CNT_W-1:0] fw_m1;
  logic        ex_render, ex_done, issue, font_wr, pal_wr;
  logic [FONT_AW-1:0] rd_addr;

  logic        f_v_r;
  logic [7:0]  font_q_r;
  logic [23:0] fg_q_r, bg_q_r;
  logic        fg_ok_r, bg_ok_r;
  logic [3:0]  fg_r, bg_r;
  logic [2:0]  bit_r;
  logic [11:0] x_r;
  logic [10:0] y_r;
  logic        last_r;

  assign fw_m1_full = fw - FW_W'(1);
  assign fw_m1      = fw_m1_full[CNT_W-1:0];
  assign ex_render  = (ex_r.cmd == CMD_RENDER);
  assign ex_done    = !ex_render || (cnt_r == fw_m1);
  assign line_take  = adv && (!ex_v_r || ex_done);
  assign issue      = adv && ex_v_r;
  assign font_wr    = issue && (ex_r.cmd == CMD_FONT_WR);
  assign pal_wr     = issue && (ex_r.cmd == CMD_PAL_WR);
  assign rd_addr    = ex_r.lbase + FONT_AW'(cnt_r >> 3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r <= 1'b0;
      cnt_r  <= '0;
    end else if (line_take) begin
      ex_v_r <= line_valid;
      cnt_r  <= '0;
    end else if (issue) begin
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (line_take) ex_r <= line;
  end

  // Font memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (font_wr) font_mem[ex_r.addr] <= ex_r.wdata[7:0];
    if (adv) font_q_r <= font_mem[rd_addr];
  end

  // Palette memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (pal_wr) pal_mem[ex_r.addr[PAL_AW-1:0]] <= ex_r.wdata;
    if (adv) begin
      fg_q_r <= pal_mem[ex_r.fg];
      bg_q_r <= pal_mem[ex_r.bg];
    end
  end

  // Entries not yet written read as the default palette
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_ok_r <= '0;
      f_v_r    <= 1'b0;
    end else begin
      if (pal_wr) pal_ok_r[ex_r.addr[PAL_AW-1:0]] <= 1'b1;
      if (adv) f_v_r <= issue && ex_render;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fg_ok_r <= pal_ok_r[ex_r.fg];
      bg_ok_r <= pal_ok_r[ex_r.bg];
      fg_r    <= ex_r.fg;
      bg_r    <= ex_r.bg;
      bit_r   <= cnt_r[2:0];
      x_r     <= ex_r.colfw + 12'(cnt_r);
      y_r     <= ex_r.pix_y;
      last_r  <= (cnt_r == fw_m1);
    end
  end

  assign pix_valid     = f_v_r;
  assign pix.fg        = fg_r;
  assign pix.bg        = bg_r;
  assign pix.bit_sel   = bit_r;
  assign pix.font_byte = font_q_r;
  assign pix.fg_raw    = fg_q_r;
  assign pix.bg_raw    = bg_q_r;
  assign pix.fg_ok     = fg_ok_r;
  assign pix.bg_ok     = bg_ok_r;
  assign pix.pixel_x   = x_r;
  assign pix.pixel_y   = y_r;
  assign pix.last      = last_r;

`ifndef NO_ASSERTIONS
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_v_r && ex_render) |-> (cnt_r <= fw_m1))
    else $error("pixel counter ran past the glyph width");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(cnt_r) && $stable(ex_v_r) && $stable(f_v_r)))
    else $error("sequencer moved during an output stall");
`endif

endmodule

[test/text_mode_glyph_renderer_unit_tb.sv]
// Self-checking testbench for text_mode_glyph_renderer_unit: a directed table of command
// items, then randomized items per glyph geometry, each pixel checked against a predictor.
// Depends on tmgr_pkg and the renderer RTL only.
module text_mode_glyph_renderer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmgr_pkg::*;

  // Opcode with no meaning to the block; it must be dropped without output
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam int CYCLE_LIMIT = 500000;
  // Idle cycles let pass before a register write, once every predicted pixel is out
  localparam int SETTLE      = 16;
  localparam int LONG_HOLD   = 300;

  // Power-up palette, entry 15 in the top bits
  localparam logic [16*24-1:0] EGA_COLORS = {
    24'hFFFFFF, 24'h55FFFF, 24'hFF55FF, 24'h5555FF,
    24'hFFFF55, 24'h55FF55, 24'hFF5555, 24'h555555,
    24'hAAAAAA, 24'h00AAAA, 24'hAA00AA, 24'h0000AA,
    24'hAAAA00, 24'h00AA00, 24'hAA0000, 24'h000000
  };

  // One row of the directed table; pin marks rows whose pixels share one known color
  typedef struct {
    tmgr_in_t    item;
    bit          pin;
    logic [23:0] color;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  tmgr_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  tmgr_out_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [5:0] cfg_wdata;

  // Predictor state: font bytes, which of them hold data, palette, geometry registers
  logic [7:0]     font_mem   [FONT_BYTES];
  bit             font_known [FONT_BYTES];
  logic [23:0]    pal        [PAL_N];
  logic [FW_W-1:0] reg_fw = 5'd8;
  logic [FH_W-1:0] reg_fh = 6'd16;

  // Pixels predicted but not yet seen on the output, oldest first
  tmgr_out_t expected_pixels [$];
  tmgr_out_t want;

  int  err_cnt  = 0;
  int  cycles   = 0;
  bit  hold_req = 1'b0;   // ask the pixel sink for one long hold-off
  bit  calm     = 1'b0;   // no idling on either side while set

  text_mode_glyph_renderer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    err_cnt++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Zero reads as one, anything above the limit saturates
  function automatic int clamp_dim(input int v, input int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int glyph_w();
    return clamp_dim(reg_fw, MAX_GLYPH_WIDTH);
  endfunction

  function automatic int glyph_h();
    return clamp_dim(reg_fh, MAX_GLYPH_HEIGHT);
  endfunction

  function automatic int line_bytes();
    return (glyph_w() - 1) / 8 + 1;
  endfunction

  // First font byte of one scanline of one glyph
  function automatic int line_base(input int ch, input int scan);
    return ch * glyph_h() * line_bytes() + scan * line_bytes();
  endfunction

  // Update the stores for a write, or queue the pixels of a render scanline.
  // Font bits are taken MSB first; pin overrides the color with a table value.
  function automatic void predict_item(input tmgr_in_t it, input bit pin,
                                       input logic [23:0] pin_color);
    int         fw;
    int         fh;
    int         base;
    logic [7:0] fbyte;
    tmgr_out_t  px;
    fw = glyph_w();
    fh = glyph_h();
    case (it.cmd)
      CMD_FONT_WR: begin
        font_mem[it.addr]   = it.wdata[7:0];
        font_known[it.addr] = 1'b1;
      end
      CMD_PAL_WR: begin
        // indexes past the palette are dropped
        if (it.addr < PAL_N) pal[it.addr[PAL_AW-1:0]] = it.wdata;
      end
      CMD_RENDER: begin
        // a scanline at or below the glyph bottom renders nothing
        if (it.scan_line < fh) begin
          base = line_base(it.cell_word[7:0], it.scan_line);
          for (int b = 0; b < fw; b++) begin
            fbyte          = font_mem[(base + b / 8) % FONT_BYTES];
            px.pixel_x     = 12'(it.cell_col * fw + b);
            px.pixel_y     = 11'(it.cell_row * fh + it.scan_line);
            px.pixel_color = fbyte[7 - b % 8] ? pal[it.cell_word[11:8]]
                                              : pal[it.cell_word[15:12]];
            if (pin) px.pixel_color = pin_color;
            px.last_pixel  = (b == fw - 1);
            expected_pixels.push_back(px);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic tmgr_in_t rand_item(input logic [1:0] cmd);
    tmgr_in_t it;
    it.cmd       = cmd;
    it.addr      = 14'($urandom);
    it.wdata     = 24'($urandom);
    it.cell_word = 16'($urandom);
    it.cell_row  = 6'($urandom);
    it.cell_col  = 8'($urandom);
    it.scan_line = 5'($urandom);
    return it;
  endfunction

  function automatic stim_row_t stim(input logic [1:0] cmd, input logic [13:0] addr,
                                     input logic [23:0] wdata, input logic [15:0] word,
                                     input logic [5:0] r, input logic [7:0] c,
                                     input logic [4:0] s, input bit pin,
                                     input logic [23:0] color);
    stim_row_t sr;
    sr.item.cmd       = cmd;
    sr.item.addr      = addr;
    sr.item.wdata     = wdata;
    sr.item.cell_word = word;
    sr.item.cell_row  = r;
    sr.item.cell_col  = c;
    sr.item.scan_line = s;
    sr.pin            = pin;
    sr.color          = color;
    return sr;
  endfunction

  // Offer one item after a random gap and hold it until accepted.
  // Valid is only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_item(input tmgr_in_t it, input bit pin, input logic [23:0] pin_color);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it, pin, pin_color);
  endtask

  // Stop offering, wait for every predicted pixel, then let the pipe settle
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write both geometry registers back to back; only called with the block idle
  task automatic load_geometry(input logic [5:0] w, input logic [5:0] h);
    cfg_index <= CFG_FONT_WIDTH;
    cfg_wdata <= w;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_fw = w[FW_W-1:0];
    cfg_index <= CFG_FONT_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_fh = h;
    cfg_valid <= 1'b0;
  endtask

  // Random render. Every font byte it reads gets written first, since an unwritten
  // byte has no defined value. Most renders pick from a few glyphs to keep fills rare.
  task automatic send_render_random();
    tmgr_in_t it;
    tmgr_in_t fill;
    int       base;
    it = rand_item(CMD_RENDER);
    if ($urandom_range(2) != 0) it.cell_word[7:0] = 8'($urandom_range(7));
    if ($urandom_range(9) != 0) it.scan_line = 5'($urandom_range(glyph_h() - 1));
    if (it.scan_line < glyph_h()) begin
      base = line_base(it.cell_word[7:0], it.scan_line);
      for (int k = 0; k < line_bytes(); k++) begin
        if (!font_known[base + k]) begin
          fill      = rand_item(CMD_FONT_WR);
          fill.addr = 14'(base + k);
          send_item(fill, 1'b0, '0);
        end
      end
    end
    send_item(it, 1'b0, '0);
  endtask

  // Mix of renders, font and palette writes and dropped opcodes; mid_pause
  // stops the sender halfway until every pixel is out.
  task automatic run_random(input int n, input bit mid_pause);
    tmgr_in_t it;
    int       pick;
    for (int i = 0; i < n; i++) begin
      if (mid_pause && i == n / 2) drain(2);
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_render_random();
      end else if (pick < 75) begin
        it = rand_item(CMD_FONT_WR);
        // half the time, rewrite a line of a glyph that renders often
        if ($urandom_range(1) != 0)
          it.addr = 14'(line_base($urandom_range(7), $urandom_range(glyph_h() - 1)));
        send_item(it, 1'b0, '0);
      end else if (pick < 93) begin
        it = rand_item(CMD_PAL_WR);
        if ($urandom_range(3) != 0) it.addr = 14'($urandom_range(PAL_N - 1));
        send_item(it, 1'b0, '0);
      end else begin
        send_item(rand_item(CMD_NONE), 1'b0, '0);
      end
    end
  endtask

  // Pixel sink: random back-pressure, plus one long hold-off on request.
  // The hold is counted here, so the sender keeps offering and the block fills up.
  initial begin : pixel_sink
    int n;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        n = calm ? 16 : $urandom_range(12, 1);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Compare each accepted pixel with the oldest prediction, field by field
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        flag_error($sformatf("unexpected pixel x=%0d y=%0d color=%06h",
                             out_data.pixel_x, out_data.pixel_y, out_data.pixel_color));
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.pixel_x !== want.pixel_x)
          flag_error($sformatf("pixel_x got %0d want %0d", out_data.pixel_x, want.pixel_x));
        if (out_data.pixel_y !== want.pixel_y)
          flag_error($sformatf("pixel_y got %0d want %0d (x=%0d)",
                               out_data.pixel_y, want.pixel_y, want.pixel_x));
        if (out_data.pixel_color !== want.pixel_color)
          flag_error($sformatf("pixel_color got %06h want %06h (x=%0d y=%0d)",
                               out_data.pixel_color, want.pixel_color,
                               want.pixel_x, want.pixel_y));
        if (out_data.last_pixel !== want.last_pixel)
          flag_error($sformatf("last_pixel got %0b want %0b (x=%0d y=%0d)",
                               out_data.last_pixel, want.last_pixel,
                               want.pixel_x, want.pixel_y));
      end
    end
  end

  // Watchdog: far above the slowest legal run
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t rows [$];
    for (int i = 0; i < PAL_N; i++) pal[i] = EGA_COLORS[i*24 +: 24];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FONT_WIDTH;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at reset geometry (8 wide, 16 tall, one byte per line).
    // Glyph 0 line 0 is all ones, line 1 all zeros, so those pixels take one color.
    rows.push_back(stim(CMD_FONT_WR, 14'd0, 24'h0000FF, 16'h0, 6'd0, 8'd0, 5'd0, 0, 0));
    rows.push_back(stim(CMD_FONT_WR, 14'd1, 24'hFFFF00, 16'h0, 6'd0, 8'd0, 5'd0, 0, 0));
    // default palette: foreground 15, background 1, foreground 8
    rows.push_back(stim(CMD_RENDER, 14'd0, 24'h0, 16'h1F00, 6'd0, 8'd0, 5'd0, 1, 24'hFFFFFF));
    rows.push_back(stim(CMD_RENDER, 14'd0, 24'h0, 16'h1F00, 6'd0, 8'd0, 5'd1, 1, 24'hAA0000));
    rows.push_back(stim(CMD_RENDER, 14'd0, 24'h0, 16'hF800, 6'd5, 8'd9, 5'd0, 1, 24'h555555));
    // recolor entry 15, render at the far corner of the screen
    rows.push_back(stim(CMD_PAL_WR, 14'd15, 24'h000000, 16'h0, 6'd0, 8'd0, 5'd0, 0, 0));
    rows.push_back(stim(CMD_RENDER, 14'd0, 24'h0, 16'h0F00, 6'd63, 8'd255, 5'd0,
                        1, 24'h000000));
    // palette indexes past the end must be dropped
    rows.push_back(stim(CMD_PAL_WR, 14'd16, 24'hFFFFFF, 16'h0, 6'd0, 8'd0, 5'd0, 0, 0));
    rows.push_back(stim(CMD_PAL_WR, 14'h3FFF, 24'hFFFFFF, 16'h0, 6'd0, 8'd0, 5'd0, 0, 0));
    rows.push_back(stim(CMD_RENDER, 14'h3FFF, 24'hFFFFFF, 16'h0F00, 6'd1, 8'd1, 5'd0,
                        1, 24'h000000));
    rows.push_back(stim(CMD_PAL_WR, 14'd0, 24'hFFFFFF, 16'h0, 6'd0, 8'd0, 5'd0, 0, 0));
    rows.push_back(stim(CMD_RENDER, 14'd0, 24'h0, 16'h0000, 6'd2, 8'd3, 5'd1, 1, 24'hFFFFFF));
    // unused opcode, and scanlines at and far past the glyph bottom: no pixels
    rows.push_back(stim(CMD_NONE, 14'h3FFF, 24'hFFFFFF, 16'hFFFF, 6'd63, 8'd255, 5'd31,
                        0, 0));
    rows.push_back(stim(CMD_RENDER, 14'h3FFF, 24'hFFFFFF, 16'hFFFF, 6'd63, 8'd255, 5'd16,
                        0, 0));
    rows.push_back(stim(CMD_RENDER, 14'd0, 24'h0, 16'hFFFF, 6'd0, 8'd0, 5'd31, 0, 0));
    // top font address; only the low byte of wdata is stored
    rows.push_back(stim(CMD_FONT_WR, 14'h3FFF, 24'hFFFFA5, 16'h0, 6'd0, 8'd0, 5'd0, 0, 0));
    rows.push_back(stim(CMD_FONT_WR, 14'd4095, 24'h000096, 16'h0, 6'd0, 8'd0, 5'd0, 0, 0));
    rows.push_back(stim(CMD_RENDER, 14'd0, 24'h0, 16'h70FF, 6'd1, 8'd2, 5'd15, 0, 0));
    rows.push_back(stim(CMD_FONT_WR, 14'd2, 24'h000081, 16'h0, 6'd0, 8'd0, 5'd0, 0, 0));
    rows.push_back(stim(CMD_RENDER, 14'd0, 24'h0, 16'h4E00, 6'd40, 8'd100, 5'd2, 0, 0));
    rows.push_back(stim(CMD_PAL_WR, 14'd15, 24'hFFFFFF, 16'h0, 6'd0, 8'd0, 5'd0, 0, 0));
    rows.push_back(stim(CMD_RENDER, 14'd0, 24'h0, 16'hAF00, 6'd7, 8'd7, 5'd0, 1, 24'hFFFFFF));
    foreach (rows[k]) send_item(rows[k].item, rows[k].pin, rows[k].color);

    // Random part, one phase per geometry; registers change only once drained
    run_random(14, 1'b0);

    drain(SETTLE);
    load_geometry(6'd16, 6'd32);      // widest and tallest, two bytes per line
    hold_req = 1'b1;                  // sink stalls long while items keep coming
    run_random(16, 1'b1);

    drain(SETTLE);
    load_geometry(6'd1, 6'd1);        // single pixel, single scanline
    run_random(14, 1'b0);

    drain(SETTLE);
    load_geometry(6'd0, 6'd0);        // zero reads as one
    run_random(12, 1'b0);

    drain(SETTLE);
    load_geometry(6'd63, 6'd63);      // width masks to 31, both saturate
    run_random(14, 1'b1);

    drain(SETTLE);
    load_geometry(6'($urandom_range(15, 2)), 6'($urandom_range(31, 2)));
    run_random(14, 1'b0);

    drain(SETTLE);
    load_geometry(6'd8, 6'd16);       // back to reset geometry, no idling at all
    calm = 1'b1;
    run_random(12, 1'b0);

    drain(24);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[text_mode_glyph_renderer_unit.f]
rtl/tmgr_pkg.sv
rtl/tmgr_front.sv
rtl/tmgr_scan.sv
rtl/text_mode_glyph_renderer_unit.sv
test/text_mode_glyph_renderer_unit_tb.sv
